// ===== hdl/dapd_pkg.sv =====
// Shared types, constants, helpers and the control program of the damped allpass block.
`default_nettype none
package dapd_pkg;

    localparam int SAMPLE_W      = 24;
    localparam int GAIN_W        = 17;
    localparam int DELAY_W       = 12;
    localparam int DCNT_W        = $clog2(DELAY_W);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 17;
    localparam int MAX_DELAY_DEF = 4096;
    localparam int MUL_B_W       = GAIN_W + 1;
    localparam int PROD_W        = SAMPLE_W + MUL_B_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int FRAC_W        = 16;
    localparam int RND_W         = ACC_W - FRAC_W;
    localparam int SUM_W         = RND_W + 1;

    localparam logic [GAIN_W-1:0]       GAIN_ONE = GAIN_W'(65536);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(32768);
    localparam logic [DELAY_W-1:0]      DELAY_RST = DELAY_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY     = 2'd0,
        CFG_AP_GAIN   = 2'd1,
        CFG_DAMP_EN   = 2'd2,
        CFG_DAMP_GAIN = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        STEP_IDLE   = 4'd0,
        STEP_MUL_GD = 4'd1,
        STEP_ACC_GD = 4'd2,
        STEP_W_SUM  = 4'd3,
        STEP_MUL_GW = 4'd4,
        STEP_ACC_GW = 4'd5,
        STEP_Y_DIFF = 4'd6,
        STEP_MUL_WC = 4'd7,
        STEP_MUL_LP = 4'd8,
        STEP_ACC_LP = 4'd9,
        STEP_W_DAMP = 4'd10,
        STEP_WRITE  = 4'd11
    } t_step;

    typedef enum logic [1:0] {
        A_D  = 2'd0,
        A_W  = 2'd1,
        A_LP = 2'd2
    } t_a_sel;

    typedef enum logic [1:0] {
        B_G   = 2'd0,
        B_G2  = 2'd1,
        B_G2C = 2'd2
    } t_b_sel;

    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_W_SUM  = 2'd1,
        WR_Y_DIFF = 2'd2,
        WR_W_DAMP = 2'd3
    } t_wr_op;

    typedef enum logic [1:0] {
        C_NONE      = 2'd0,
        C_NO_ACCEPT = 2'd1,
        C_DAMP_OFF  = 2'd2,
        C_OUT_BUSY  = 2'd3
    } t_cond;

    typedef struct packed {
        t_a_sel  a_sel;
        t_b_sel  b_sel;
        logic    mul_en;
        t_acc_op acc_op;
        t_wr_op  wr_op;
        t_cond   cond;
        t_step   target;
        logic    last;
        logic    emit;
    } t_ctrl;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(8388607);
        lo = -SUM_W'(8388608);
        if (v > hi) begin
            return SAMPLE_W'(8388607);
        end else if (v < lo) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '{a_sel: A_D, b_sel: B_G, mul_en: 1'b0, acc_op: ACC_NONE, wr_op: WR_NONE,
              cond: C_NONE, target: STEP_IDLE, last: 1'b0, emit: 1'b0};
        case (s)
            STEP_IDLE: begin
                c.cond   = C_NO_ACCEPT;
                c.target = STEP_IDLE;
            end
            STEP_MUL_GD: begin
                c.a_sel  = A_D;
                c.b_sel  = B_G;
                c.mul_en = 1'b1;
            end
            STEP_ACC_GD: c.acc_op = ACC_LOAD;
            STEP_W_SUM:  c.wr_op  = WR_W_SUM;
            STEP_MUL_GW: begin
                c.a_sel  = A_W;
                c.b_sel  = B_G;
                c.mul_en = 1'b1;
            end
            STEP_ACC_GW: c.acc_op = ACC_LOAD;
            STEP_Y_DIFF: begin
                c.wr_op  = WR_Y_DIFF;
                c.cond   = C_DAMP_OFF;
                c.target = STEP_WRITE;
            end
            STEP_MUL_WC: begin
                c.a_sel  = A_W;
                c.b_sel  = B_G2C;
                c.mul_en = 1'b1;
            end
            STEP_MUL_LP: begin
                c.a_sel  = A_LP;
                c.b_sel  = B_G2;
                c.mul_en = 1'b1;
                c.acc_op = ACC_LOAD;
            end
            STEP_ACC_LP: c.acc_op = ACC_ADD;
            STEP_W_DAMP: c.wr_op  = WR_W_DAMP;
            STEP_WRITE: begin
                c.cond   = C_OUT_BUSY;
                c.target = STEP_WRITE;
                c.last   = 1'b1;
                c.emit   = 1'b1;
            end
            default: c.last = 1'b1;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dapd_delay_line.sv =====
// Circular sample store with fill count, delay reduction and registered read.
`default_nettype none
module dapd_delay_line
    import dapd_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_dl_we,
    input  wire [DELAY_W-1:0]          i_dl,
    output logic                       o_busy,
    input  wire                        i_rd_en,
    output logic signed [SAMPLE_W-1:0] o_rd_data,
    input  wire                        i_wr_en,
    input  wire signed [SAMPLE_W-1:0]  i_wr_data
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int FW = $clog2(MAX_DELAY + 1);
    localparam int RW = AW + 1;
    localparam logic [RW-1:0] M_RW = RW'(MAX_DELAY);
    localparam int RCP_W = DELAY_W + 2;
    localparam int PW    = DELAY_W + RCP_W;
    localparam int SH    = DELAY_W + AW;
    localparam int QW    = DELAY_W + AW + 1;
    localparam longint RECIP_L =
        ((longint'(1) <<< SH) + longint'(MAX_DELAY) - longint'(1)) / longint'(MAX_DELAY);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
    localparam logic [QW-1:0]    M_QW  = QW'(MAX_DELAY);

    logic signed [SAMPLE_W-1:0] r_mem [MAX_DELAY];
    logic signed [SAMPLE_W-1:0] r_q;
    logic                       r_q_vld;
    logic [AW-1:0]              r_wp;
    logic [FW-1:0]              r_fill;
    logic [AW-1:0]              r_dlm;
    logic [DELAY_W-1:0]         r_dl;
    logic [DELAY_W-1:0]         r_quo;
    logic                       r_phase;
    logic                       r_busy;

    logic [PW-1:0]      prod;
    logic [DELAY_W-1:0] quo;
    logic [QW-1:0]      qm;
    logic [QW-1:0]      rem;
    logic [RW-1:0]      rd_s;
    logic [RW-1:0]      rd_m;
    logic [AW-1:0]      rd_addr;

    // Delay modulo store depth: reciprocal multiply for the quotient, then the remainder.
    always_comb begin
        prod = {{RCP_W{1'b0}}, r_dl} * {{DELAY_W{1'b0}}, RECIP};
        quo  = DELAY_W'(prod >> SH);
        qm   = {{(AW+1){1'b0}}, r_quo} * M_QW;
        rem  = {{(AW+1){1'b0}}, r_dl} - qm;
        rd_s = {1'b0, r_wp} + M_RW - {1'b0, r_dlm};
        rd_m = (rd_s >= M_RW) ? rd_s - M_RW : rd_s;
    end

    assign rd_addr   = rd_m[AW-1:0];
    assign o_busy    = r_busy;
    assign o_rd_data = r_q_vld ? r_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dlm  <= AW'(DELAY_RST % MAX_DELAY);
        end else if (i_dl_we) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_phase) begin
            r_busy <= 1'b0;
            r_dlm  <= rem[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dl_we) begin
            r_dl    <= i_dl;
            r_phase <= 1'b0;
        end else if (r_busy && !r_phase) begin
            r_quo   <= quo;
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_fill  <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_q_vld <= (r_fill > FW'(rd_addr));
            end
            if (i_wr_en) begin
                r_wp <= (r_wp == AW'(MAX_DELAY - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill != FW'(MAX_DELAY)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[rd_addr];
        end
        if (i_wr_en) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/delay_allpass_with_damping_unit.sv =====
// Top level: damped Schroeder allpass on a circular delay store, microcoded datapath.
//
// One signed Q1.23 sample in, one out. A single shared 24x18 multiplier is stepped by a
// twelve-entry control program; the dependent chain g*d -> w -> g*w -> y (and, with
// damping, w*(1-g2) + lp*g2) sets the rate: a new item is accepted only once the previous
// one has run through the program, which takes more steps with damping on, and any wait of
// the previous result in the output register adds to that. Writing the delay register starts a
// reduction of the delay modulo the store depth, during which no sample is taken.
// The store needs no clearing pass: a fill count makes entries never written read as zero.
`default_nettype none
module delay_allpass_with_damping_unit
    import dapd_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire signed [SAMPLE_W-1:0]  i_in_sample,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    input  wire                        i_cfg_we,
    input  wire [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [CFG_DATA_W-1:0]       i_cfg_data
);

    t_step                      r_step;
    t_step                      n_step;
    t_ctrl                      cw;
    logic [GAIN_W-1:0]          r_ap_gain;
    logic                       r_damp_en;
    logic [GAIN_W-1:0]          r_damp_gain;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_w;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [SAMPLE_W-1:0] r_lp;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_o_sample;

    logic                       dl_busy;
    logic signed [SAMPLE_W-1:0] dly_d;
    logic                       accept;
    logic                       out_busy;
    logic                       emit_go;
    logic [GAIN_W-1:0]          g;
    logic [GAIN_W-1:0]          g2;
    logic signed [SAMPLE_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    prod_x;
    logic signed [RND_W-1:0]    rnd;
    logic signed [SUM_W-1:0]    rnd_x;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    y_diff;

    dapd_delay_line #(
        .MAX_DELAY(MAX_DELAY)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dl_we  (i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_DELAY)),
        .i_dl     (i_cfg_data[DELAY_W-1:0]),
        .o_busy   (dl_busy),
        .i_rd_en  (accept),
        .o_rd_data(dly_d),
        .i_wr_en  (emit_go),
        .i_wr_data(r_w)
    );

    assign o_in_ready   = (r_step == STEP_IDLE) && !dl_busy;
    assign accept       = i_in_valid && o_in_ready;
    assign out_busy     = r_o_valid && !i_out_ready;
    assign emit_go      = cw.emit && !out_busy;
    assign o_out_valid  = r_o_valid;
    assign o_out_sample = r_o_sample;

    always_comb begin
        cw = ucode(r_step);
    end

    always_comb begin
        logic jump;
        case (cw.cond)
            C_NO_ACCEPT: jump = !accept;
            C_DAMP_OFF:  jump = !r_damp_en;
            C_OUT_BUSY:  jump = out_busy;
            default:     jump = 1'b0;
        endcase
        if (jump) begin
            n_step = cw.target;
        end else if (cw.last) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = t_step'(r_step + 4'd1);
        end
    end

    always_comb begin
        g  = clamp_gain(r_ap_gain);
        g2 = clamp_gain(r_damp_gain);
        case (cw.a_sel)
            A_W:     mul_a = r_w;
            A_LP:    mul_a = r_lp;
            default: mul_a = dly_d;
        endcase
        case (cw.b_sel)
            B_G2:    mul_b = {1'b0, g2};
            B_G2C:   mul_b = {1'b0, GAIN_ONE - g2};
            default: mul_b = {1'b0, g};
        endcase
        mul_p  = mul_a * mul_b;
        prod_x = {r_prod[PROD_W-1], r_prod};
        rnd    = r_acc[ACC_W-1:FRAC_W];
        rnd_x  = {rnd[RND_W-1], rnd};
        w_sum  = SUM_W'(r_x) + rnd_x;
        y_diff = SUM_W'(dly_d) - rnd_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_ap_gain   <= '0;
            r_damp_en   <= 1'b0;
            r_damp_gain <= '0;
            r_lp        <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_step <= n_step;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_AP_GAIN:   r_ap_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_DAMP_EN:   r_damp_en   <= i_cfg_data[0];
                    CFG_DAMP_GAIN: r_damp_gain <= i_cfg_data[GAIN_W-1:0];
                    default:       ;
                endcase
            end
            if (cw.wr_op == WR_W_DAMP) begin
                r_lp <= sat_sample(rnd_x);
            end
            if (emit_go) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_in_sample;
        end
        if (cw.mul_en) begin
            r_prod <= mul_p;
        end
        case (cw.acc_op)
            ACC_LOAD: r_acc <= prod_x + ACC_HALF;
            ACC_ADD:  r_acc <= r_acc + prod_x;
            default:  ;
        endcase
        case (cw.wr_op)
            WR_W_SUM:  r_w <= sat_sample(w_sum);
            WR_Y_DIFF: r_y <= sat_sample(y_diff);
            WR_W_DAMP: r_w <= sat_sample(rnd_x);
            default:   ;
        endcase
        if (emit_go) begin
            r_o_sample <= r_y;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_step == STEP_MUL_GD))
        else $error("accepted beat did not start the program");

    a_write_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_go |=> (o_out_valid && (o_out_sample == $past(r_y))))
        else $error("store write without matching output beat");

    a_lp_damped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_W_DAMP) |-> r_damp_en)
        else $error("damping step reached with damping off");

    a_lp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_IDLE) |=> $stable(r_lp))
        else $error("lowpass state changed outside damping step");

endmodule
`default_nettype wire
